FILE: rtl/aabb_collide_and_resolve_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the box collision block
// Immediate-consequence and next-cycle property forms, reset disabled.
// ---------------------------------------------------------------------------
`ifndef AABB_COLLIDE_AND_RESOLVE_MACROS_SVH
`define AABB_COLLIDE_AND_RESOLVE_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define AABB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define AABB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/aabb_pkg.sv
// ---------------------------------------------------------------------------
// aabb_pkg
// Shared sizes, codes and word types of the box collision block.
// ---------------------------------------------------------------------------
package aabb_pkg;

   localparam int MAX_BOXES   = 64;
   localparam int IDX_W       = $clog2(MAX_BOXES);
   localparam int CNT_W       = $clog2(MAX_BOXES + 1);
   localparam int ENTRY_IDX_W = 6;
   localparam int COORD_W     = 16;
   localparam int DIM_W       = 15;
   localparam int EDGE_W      = 17;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_HORZ  = 2'd1;
   localparam logic [1:0] MODE_VERT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
   } entry_type;

   // two's complement edges, one bit wider than a coordinate
   typedef struct packed {
      logic [EDGE_W-1:0] left;
      logic [EDGE_W-1:0] right;
      logic [EDGE_W-1:0] top;
      logic [EDGE_W-1:0] bottom;
   } edges_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [ENTRY_IDX_W-1:0] entry_index;
      logic                   entry_valid;
      logic [COORD_W-1:0]     box_x;
      logic [COORD_W-1:0]     box_y;
      logic [DIM_W-1:0]       box_width;
      logic [DIM_W-1:0]       box_height;
      logic [COORD_W-1:0]     prev_x;
      logic                   moving_down;
   } req_type;

   typedef struct packed {
      logic                   strobe;
      logic                   hit;
      logic [ENTRY_IDX_W-1:0] hit_index;
      logic [COORD_W-1:0]     new_x;
      logic [COORD_W-1:0]     new_y;
      logic                   clear_speed;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic             present;
      entry_type        entry;
   } wr_req_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic      present;
      entry_type entry;
   } rd_rsp_type;

endpackage

FILE: rtl/aabb_box_table.sv
// ---------------------------------------------------------------------------
// aabb_box_table
// Box store: one write port, one registered read port, present bits in flops.
// ---------------------------------------------------------------------------
module aabb_box_table (
   input  logic                clock,
   input  logic                reset,
   input  aabb_pkg::wr_req_type wr_req,
   input  aabb_pkg::rd_req_type rd_req,
   output aabb_pkg::rd_rsp_type rd_rsp
);

   aabb_pkg::entry_type             box_mem_ff [aabb_pkg::MAX_BOXES];
   logic [aabb_pkg::MAX_BOXES-1:0]  present_ff;
   logic [aabb_pkg::MAX_BOXES-1:0]  present_in;
   aabb_pkg::rd_rsp_type            rd_rsp_ff;

   always_comb begin
      present_in = present_ff;
      if (wr_req.en) begin
         present_in[wr_req.addr] = wr_req.present;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else begin
         present_ff <= present_in;
      end
   end

   // box fields are kept only for entries that are stored
   always_ff @(posedge clock) begin
      if (wr_req.en && wr_req.present) begin
         box_mem_ff[wr_req.addr] <= wr_req.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_rsp_ff.entry   <= box_mem_ff[rd_req.addr];
         rd_rsp_ff.present <= present_ff[rd_req.addr];
      end
   end

   assign rd_rsp = rd_rsp_ff;

endmodule

FILE: rtl/aabb_overlap_unit.sv
// ---------------------------------------------------------------------------
// aabb_overlap_unit
// Shared edge adder and strict overlap compare, used once per scanned entry.
// ---------------------------------------------------------------------------
module aabb_overlap_unit (
   input  aabb_pkg::edges_type mover,
   input  aabb_pkg::entry_type entry,
   output aabb_pkg::edges_type entry_edges,
   output logic                overlap
);

   always_comb begin
      entry_edges.left   = {entry.left[aabb_pkg::COORD_W-1], entry.left};
      entry_edges.top    = {entry.top[aabb_pkg::COORD_W-1], entry.top};
      entry_edges.right  = {entry.left[aabb_pkg::COORD_W-1], entry.left}
                           + {2'b00, entry.width};
      entry_edges.bottom = {entry.top[aabb_pkg::COORD_W-1], entry.top}
                           + {2'b00, entry.height};
   end

   assign overlap = ($signed(mover.right)  > $signed(entry_edges.left))   &&
                    ($signed(mover.left)   < $signed(entry_edges.right))  &&
                    ($signed(mover.top)    < $signed(entry_edges.bottom)) &&
                    ($signed(mover.bottom) > $signed(entry_edges.top));

endmodule

FILE: rtl/aabb_scan_seq.sv
// ---------------------------------------------------------------------------
// aabb_scan_seq
// Sequencer: takes words, steps the table read address, tracks the first hit
// and resolves the mover position.
// ---------------------------------------------------------------------------
module aabb_scan_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  aabb_pkg::req_type    req,
   output logic                 busy,
   output aabb_pkg::wr_req_type wr_req,
   output aabb_pkg::rd_req_type rd_req,
   input  aabb_pkg::rd_rsp_type rd_rsp,
   output aabb_pkg::edges_type  mover,
   input  aabb_pkg::edges_type  entry_edges,
   input  logic                 overlap,
   output aabb_pkg::rsp_type    rsp
);

   aabb_pkg::state_type state_ff, state_in;

   logic [aabb_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             chk_act_ff, chk_act_in;
   logic                             chk_self_ff, chk_self_in;
   logic                             chk_last_ff, chk_last_in;
   logic [aabb_pkg::IDX_W-1:0]       chk_idx_ff, chk_idx_in;

   aabb_pkg::edges_type              mover_ff, mover_in;
   logic [aabb_pkg::DIM_W-1:0]       w_ff, w_in;
   logic [aabb_pkg::DIM_W-1:0]       h_ff, h_in;
   logic                             horz_ff, horz_in;
   logic                             move_right_ff, move_right_in;
   logic                             down_ff, down_in;
   logic [aabb_pkg::ENTRY_IDX_W-1:0] self_idx_ff, self_idx_in;

   logic                             hit_ff, hit_in;
   logic [aabb_pkg::IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   aabb_pkg::edges_type              hit_edges_ff, hit_edges_in;

   aabb_pkg::rsp_type                rsp_ff, rsp_in;

   logic accept;
   logic is_query;
   logic issue;
   logic hit_now;
   logic [aabb_pkg::EDGE_W-1:0] horz_pos;
   logic [aabb_pkg::EDGE_W-1:0] vert_pos;

   function automatic logic [aabb_pkg::COORD_W-1:0] sat16(
      input logic [aabb_pkg::EDGE_W-1:0] v
   );
      logic [aabb_pkg::COORD_W-1:0] r;
      if (v[aabb_pkg::EDGE_W-1] != v[aabb_pkg::COORD_W-1]) begin
         r = v[aabb_pkg::EDGE_W-1] ? {1'b1, {(aabb_pkg::COORD_W-1){1'b0}}}
                                   : {1'b0, {(aabb_pkg::COORD_W-1){1'b1}}};
      end else begin
         r = v[aabb_pkg::COORD_W-1:0];
      end
      return r;
   endfunction

   // FSM outputs
   always_comb begin
      busy     = (state_ff != aabb_pkg::ST_IDLE);
      accept   = start && !busy;
      is_query = (req.mode == aabb_pkg::MODE_HORZ) || (req.mode == aabb_pkg::MODE_VERT);
      issue    = (state_ff == aabb_pkg::ST_SCAN)
                 && (cnt_ff < aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES));
   end

   assign hit_now = (state_ff == aabb_pkg::ST_SCAN) && chk_act_ff && rd_rsp.present
                    && !chk_self_ff && overlap;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aabb_pkg::ST_IDLE: begin
            if (accept && is_query) begin
               state_in = aabb_pkg::ST_SCAN;
            end
         end
         aabb_pkg::ST_SCAN: begin
            if (hit_now || (chk_act_ff && chk_last_ff)) begin
               state_in = aabb_pkg::ST_RESOLVE;
            end
         end
         aabb_pkg::ST_RESOLVE: begin
            state_in = aabb_pkg::ST_IDLE;
         end
         default: begin
            state_in = aabb_pkg::ST_IDLE;
         end
      endcase
   end

   // table ports
   always_comb begin
      wr_req.en      = accept && (req.mode == aabb_pkg::MODE_WRITE)
                       && (32'(req.entry_index) < aabb_pkg::MAX_BOXES);
      wr_req.addr    = aabb_pkg::IDX_W'(req.entry_index);
      wr_req.present = req.entry_valid;
      wr_req.entry   = '{left:   req.box_x,
                         top:    req.box_y,
                         width:  req.box_width,
                         height: req.box_height};
      rd_req.en      = issue;
      rd_req.addr    = cnt_ff[aabb_pkg::IDX_W-1:0];
   end

   // datapath
   always_comb begin
      cnt_in        = cnt_ff;
      chk_act_in    = 1'b0;
      chk_self_in   = chk_self_ff;
      chk_last_in   = chk_last_ff;
      chk_idx_in    = chk_idx_ff;
      mover_in      = mover_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      horz_in       = horz_ff;
      move_right_in = move_right_ff;
      down_in       = down_ff;
      self_idx_in   = self_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_edges_in  = hit_edges_ff;
      rsp_in        = rsp_ff;
      rsp_in.strobe = 1'b0;

      horz_pos = move_right_ff ? (hit_edges_ff.left - {2'b00, w_ff}) : hit_edges_ff.right;
      vert_pos = down_ff ? (hit_edges_ff.top - {2'b00, h_ff}) : hit_edges_ff.bottom;

      if ((state_ff == aabb_pkg::ST_IDLE) && accept && is_query) begin
         mover_in.left   = {req.box_x[aabb_pkg::COORD_W-1], req.box_x};
         mover_in.top    = {req.box_y[aabb_pkg::COORD_W-1], req.box_y};
         mover_in.right  = {req.box_x[aabb_pkg::COORD_W-1], req.box_x}
                           + {2'b00, req.box_width};
         mover_in.bottom = {req.box_y[aabb_pkg::COORD_W-1], req.box_y}
                           + {2'b00, req.box_height};
         w_in          = req.box_width;
         h_in          = req.box_height;
         horz_in       = (req.mode == aabb_pkg::MODE_HORZ);
         move_right_in = $signed(req.prev_x) < $signed(req.box_x);
         down_in       = req.moving_down;
         self_idx_in   = req.entry_index;
         cnt_in        = '0;
         hit_in        = 1'b0;
         hit_idx_in    = '0;
      end

      if (state_ff == aabb_pkg::ST_SCAN) begin
         // issue stage: address out, flags registered in step with the read data
         if (issue) begin
            cnt_in      = cnt_ff + aabb_pkg::CNT_W'(1);
            chk_act_in  = 1'b1;
            chk_self_in = (32'(cnt_ff) == 32'(self_idx_ff));
            chk_last_in = (cnt_ff == aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES - 1));
            chk_idx_in  = cnt_ff[aabb_pkg::IDX_W-1:0];
         end
         if (hit_now) begin
            chk_act_in   = 1'b0;
            hit_in       = 1'b1;
            hit_idx_in   = chk_idx_ff;
            hit_edges_in = entry_edges;
         end
      end

      if (state_ff == aabb_pkg::ST_RESOLVE) begin
         rsp_in.strobe      = 1'b1;
         rsp_in.hit         = hit_ff;
         rsp_in.clear_speed = hit_ff;
         rsp_in.hit_index   = hit_ff ? aabb_pkg::ENTRY_IDX_W'(hit_idx_ff) : '0;
         rsp_in.new_x       = (hit_ff && horz_ff) ? sat16(horz_pos)
                                                  : mover_ff.left[aabb_pkg::COORD_W-1:0];
         rsp_in.new_y       = (hit_ff && !horz_ff) ? sat16(vert_pos)
                                                   : mover_ff.top[aabb_pkg::COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= aabb_pkg::ST_IDLE;
         chk_act_ff    <= 1'b0;
         rsp_ff.strobe <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_act_ff    <= chk_act_in;
         rsp_ff        <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff             <= cnt_in;
      chk_self_ff        <= chk_self_in;
      chk_last_ff        <= chk_last_in;
      chk_idx_ff         <= chk_idx_in;
      mover_ff           <= mover_in;
      w_ff               <= w_in;
      h_ff               <= h_in;
      horz_ff            <= horz_in;
      move_right_ff      <= move_right_in;
      down_ff            <= down_in;
      self_idx_ff        <= self_idx_in;
      hit_ff             <= hit_in;
      hit_idx_ff         <= hit_idx_in;
      hit_edges_ff       <= hit_edges_in;
   end

   assign mover = mover_ff;
   assign rsp   = rsp_ff;

endmodule

FILE: rtl/aabb_collide_and_resolve.sv
// ---------------------------------------------------------------------------
// aabb_collide_and_resolve: box table with first-overlap query and resolve
// Write word: taken while busy is low, busy stays low, no result.
// Query word: busy while scanning up to the first hit or the last entry and
// then while resolving; rsp_strobe follows in the next cycle, with busy low.
// One table entry is read per cycle through the single read port.
// Reset clears the present bits at once; box fields are valid once written.
// ---------------------------------------------------------------------------
module aabb_collide_and_resolve (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [5:0]  req_entry_index,
   input  logic        req_entry_valid,
   input  logic signed [15:0] req_box_x,
   input  logic signed [15:0] req_box_y,
   input  logic [14:0] req_box_width,
   input  logic [14:0] req_box_height,
   input  logic signed [15:0] req_prev_x,
   input  logic        req_moving_down,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic [5:0]  rsp_hit_index,
   output logic signed [15:0] rsp_new_x,
   output logic signed [15:0] rsp_new_y,
   output logic        rsp_clear_speed
);

   aabb_pkg::req_type    req;
   aabb_pkg::rsp_type    rsp;
   aabb_pkg::wr_req_type wr_req;
   aabb_pkg::rd_req_type rd_req;
   aabb_pkg::rd_rsp_type rd_rsp;
   aabb_pkg::edges_type  mover;
   aabb_pkg::edges_type  entry_edges;
   logic                 overlap;

   assign req = '{mode:        req_mode,
                  entry_index: req_entry_index,
                  entry_valid: req_entry_valid,
                  box_x:       req_box_x,
                  box_y:       req_box_y,
                  box_width:   req_box_width,
                  box_height:  req_box_height,
                  prev_x:      req_prev_x,
                  moving_down: req_moving_down};

   aabb_scan_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .busy        (busy),
      .wr_req      (wr_req),
      .rd_req      (rd_req),
      .rd_rsp      (rd_rsp),
      .mover       (mover),
      .entry_edges (entry_edges),
      .overlap     (overlap),
      .rsp         (rsp)
   );

   aabb_box_table u_table (
      .clock  (clock),
      .reset  (reset),
      .wr_req (wr_req),
      .rd_req (rd_req),
      .rd_rsp (rd_rsp)
   );

   aabb_overlap_unit u_overlap (
      .mover       (mover),
      .entry       (rd_rsp.entry),
      .entry_edges (entry_edges),
      .overlap     (overlap)
   );

   assign rsp_strobe      = rsp.strobe;
   assign rsp_hit         = rsp.hit;
   assign rsp_hit_index   = rsp.hit_index;
   assign rsp_new_x       = rsp.new_x;
   assign rsp_new_y       = rsp.new_y;
   assign rsp_clear_speed = rsp.clear_speed;

endmodule

FILE: rtl/aabb_checker.sv
// ---------------------------------------------------------------------------
// aabb_checker
// Port-level checks of the query sequencing and result words.
// ---------------------------------------------------------------------------
`include "aabb_collide_and_resolve_macros.svh"

module aabb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_mode,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic [5:0]  rsp_hit_index,
   input logic        rsp_clear_speed
);

   logic take_query;
   logic take_other;

   assign take_query = start && !busy
                       && ((req_mode == aabb_pkg::MODE_HORZ)
                           || (req_mode == aabb_pkg::MODE_VERT));
   assign take_other = start && !busy && !take_query;

   `AABB_ASSERT_NEXT(a_query_busy, clock, reset, take_query, busy, "query word did not raise busy")
   `AABB_ASSERT_NEXT(a_write_idle, clock, reset, take_other, !busy, "write word raised busy")
   `AABB_ASSERT_SAME(a_done_strobe, clock, reset, !$past(reset) && $fell(busy), rsp_strobe, "no result")
   `AABB_ASSERT_SAME(a_clear_hit, clock, reset, rsp_strobe, rsp_clear_speed == rsp_hit, "clear != hit")
   `AABB_ASSERT_SAME(a_miss_index, clock, reset, rsp_strobe && !rsp_hit, rsp_hit_index == 6'd0, "miss index")

endmodule

bind aabb_collide_and_resolve aabb_checker u_checker (.*);

FILE: tb/aabb_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_tb_pkg: box table mirror and result checker
// Keeps a private copy of the box table, works out the resolved move of each
// accepted query word and compares the block's result words in order.
// ---------------------------------------------------------------------------
package aabb_tb_pkg;

   // the block ignores this mode
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      bit                 hit;
      bit [5:0]           hit_index;
      logic signed [15:0] new_x;
      logic signed [15:0] new_y;
      bit                 clear_speed;
   } move_type;

   function automatic logic signed [15:0] clamp_coord(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   class box_table_scoreboard;
      logic signed [15:0] left_edge[aabb_pkg::MAX_BOXES];
      logic signed [15:0] top_edge[aabb_pkg::MAX_BOXES];
      logic [14:0]        width_of[aabb_pkg::MAX_BOXES];
      logic [14:0]        height_of[aabb_pkg::MAX_BOXES];
      bit                 present[aabb_pkg::MAX_BOXES];
      move_type           expected_moves[$];
      int                 fail_count;

      function new();
         fail_count = 0;
         foreach (present[i]) present[i] = 1'b0;
      endfunction

      function int pending();
         return expected_moves.size();
      endfunction

      // first strict overlap in index order, skipping the mover's own entry
      function move_type resolve_query(aabb_pkg::req_type word);
         move_type mv;
         int       x, y, wd, ht, px, l2, r2, t2, b2;
         bit       found;
         x  = int'($signed(word.box_x));
         y  = int'($signed(word.box_y));
         px = int'($signed(word.prev_x));
         wd = int'(word.box_width);
         ht = int'(word.box_height);
         mv.hit = 1'b0;
         mv.hit_index = '0;
         mv.new_x = word.box_x;
         mv.new_y = word.box_y;
         found = 1'b0;
         for (int i = 0; i < aabb_pkg::MAX_BOXES; i++) begin
            if (!found && present[i] && i != int'(word.entry_index)) begin
               l2 = int'(left_edge[i]);
               r2 = l2 + int'(width_of[i]);
               t2 = int'(top_edge[i]);
               b2 = t2 + int'(height_of[i]);
               if (x + wd > l2 && x < r2 && y < b2 && y + ht > t2) begin
                  found = 1'b1;
                  mv.hit = 1'b1;
                  mv.hit_index = 6'(i);
                  if (word.mode == aabb_pkg::MODE_HORZ)
                     mv.new_x = clamp_coord(px < x ? l2 - wd : r2);
                  else
                     mv.new_y = clamp_coord(word.moving_down ? t2 - ht : b2);
               end
            end
         end
         mv.clear_speed = mv.hit;
         return mv;
      endfunction

      function void note_word(aabb_pkg::req_type word);
         move_type mv;
         case (word.mode)
            aabb_pkg::MODE_WRITE: begin
               if (int'(word.entry_index) < aabb_pkg::MAX_BOXES) begin
                  present[word.entry_index] = word.entry_valid;
                  if (word.entry_valid) begin
                     left_edge[word.entry_index] = word.box_x;
                     top_edge[word.entry_index]  = word.box_y;
                     width_of[word.entry_index]  = word.box_width;
                     height_of[word.entry_index] = word.box_height;
                  end
               end
            end
            aabb_pkg::MODE_HORZ, aabb_pkg::MODE_VERT: begin
               mv = resolve_query(word);
               expected_moves = {expected_moves, mv};
            end
            default: ;
         endcase
      endfunction

      function void check_move(logic hit, logic [5:0] hit_index,
                               logic signed [15:0] new_x, logic signed [15:0] new_y,
                               logic clear_speed);
         move_type mv;
         if (expected_moves.size() == 0) begin
            $error("result word with no query pending");
            fail_count++;
            return;
         end
         mv = expected_moves.pop_front();
         if (hit !== mv.hit) begin
            $error("hit: expected %0d, actual %0d", mv.hit, hit);
            fail_count++;
         end
         if (hit_index !== mv.hit_index) begin
            $error("hit_index: expected %0d, actual %0d", mv.hit_index, hit_index);
            fail_count++;
         end
         if (new_x !== mv.new_x) begin
            $error("new_x: expected %0d, actual %0d", mv.new_x, new_x);
            fail_count++;
         end
         if (new_y !== mv.new_y) begin
            $error("new_y: expected %0d, actual %0d", mv.new_y, new_y);
            fail_count++;
         end
         if (clear_speed !== mv.clear_speed) begin
            $error("clear_speed: expected %0d, actual %0d", mv.clear_speed, clear_speed);
            fail_count++;
         end
      endfunction
   endclass

endpackage

FILE: tb/tb_aabb_collide_and_resolve.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aabb_collide_and_resolve: box collision table testbench
// Fills the table and queries it with directed corner cases, then with
// random words clustered in a small area so that hits are common, under
// several sender idle rates. Every result word is checked in order.
// ---------------------------------------------------------------------------
module tb_aabb_collide_and_resolve;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_mode = '0;
   logic [5:0]         req_entry_index = '0;
   logic               req_entry_valid = 1'b0;
   logic signed [15:0] req_box_x = '0;
   logic signed [15:0] req_box_y = '0;
   logic [14:0]        req_box_width = '0;
   logic [14:0]        req_box_height = '0;
   logic signed [15:0] req_prev_x = '0;
   logic               req_moving_down = 1'b0;
   logic               rsp_strobe;
   logic               rsp_hit;
   logic [5:0]         rsp_hit_index;
   logic signed [15:0] rsp_new_x;
   logic signed [15:0] rsp_new_y;
   logic               rsp_clear_speed;

   aabb_tb_pkg::box_table_scoreboard sb = new();

   aabb_collide_and_resolve DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_entry_index(req_entry_index),
      .req_entry_valid(req_entry_valid),
      .req_box_x(req_box_x),
      .req_box_y(req_box_y),
      .req_box_width(req_box_width),
      .req_box_height(req_box_height),
      .req_prev_x(req_prev_x),
      .req_moving_down(req_moving_down),
      .rsp_strobe(rsp_strobe),
      .rsp_hit(rsp_hit),
      .rsp_hit_index(rsp_hit_index),
      .rsp_new_x(rsp_new_x),
      .rsp_new_y(rsp_new_y),
      .rsp_clear_speed(rsp_clear_speed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_move(rsp_hit, rsp_hit_index, rsp_new_x, rsp_new_y, rsp_clear_speed);
   end

   function automatic aabb_pkg::req_type make_word(logic [1:0] mode, int idx, bit valid,
                                                   int x, int y, int wd, int ht, int px,
                                                   bit down);
      aabb_pkg::req_type word;
      word.mode        = mode;
      word.entry_index = 6'(idx);
      word.entry_valid = valid;
      word.box_x       = 16'(x);
      word.box_y       = 16'(y);
      word.box_width   = 15'(wd);
      word.box_height  = 15'(ht);
      word.prev_x      = 16'(px);
      word.moving_down = down;
      return word;
   endfunction

   // mostly a small play area, sometimes anywhere
   function automatic logic [15:0] pick_coord();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 400)) - 16'd200;
   endfunction

   function automatic logic [14:0] pick_size();
      if ($urandom_range(0, 4) == 0) return 15'($urandom);
      return 15'($urandom_range(0, 120));
   endfunction

   function automatic aabb_pkg::req_type random_word();
      aabb_pkg::req_type word;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)      word.mode = aabb_pkg::MODE_WRITE;
      else if (pick < 67) word.mode = aabb_pkg::MODE_HORZ;
      else if (pick < 95) word.mode = aabb_pkg::MODE_VERT;
      else                word.mode = aabb_tb_pkg::MODE_UNUSED;
      if ($urandom_range(0, 9) < 7) word.entry_index = 6'($urandom_range(0, 15));
      else                          word.entry_index = 6'($urandom);
      word.entry_valid = ($urandom_range(0, 99) < 85);
      word.box_x       = pick_coord();
      word.box_y       = pick_coord();
      word.box_width   = pick_size();
      word.box_height  = pick_size();
      if ($urandom_range(0, 4) == 0) word.prev_x = 16'($urandom);
      else word.prev_x = word.box_x + 16'($urandom_range(0, 40)) - 16'd20;
      word.moving_down = 1'($urandom_range(0, 1));
      return word;
   endfunction

   // hold the word on the ports until the block takes it
   task automatic send_word(aabb_pkg::req_type word);
      start           <= 1'b1;
      req_mode        <= word.mode;
      req_entry_index <= word.entry_index;
      req_entry_valid <= word.entry_valid;
      req_box_x       <= word.box_x;
      req_box_y       <= word.box_y;
      req_box_width   <= word.box_width;
      req_box_height  <= word.box_height;
      req_prev_x      <= word.prev_x;
      req_moving_down <= word.moving_down;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_word(word);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic run_random(int count, int idle_pct);
      int                sent;
      aabb_pkg::req_type word;
      sent = 0;
      while (sent < count) begin
         word = random_word();
         if (word.mode != aabb_tb_pkg::MODE_UNUSED) sent++;
         send_word(word);
         if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table, then a small cluster of boxes
      send_word(make_word(aabb_pkg::MODE_HORZ, 5, 0, 5, 5, 10, 10, 0, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 0, 1, 0, 0, 10, 10, 0, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 63, 1, 100, 100, 20, 20, 0, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 62, 1, 105, 105, 20, 20, 0, 0));
      // moving right, standing still, moving left
      send_word(make_word(aabb_pkg::MODE_HORZ, 5, 0, 5, 5, 10, 10, 0, 0));
      send_word(make_word(aabb_pkg::MODE_HORZ, 5, 0, 5, 5, 10, 10, 5, 0));
      send_word(make_word(aabb_pkg::MODE_HORZ, 5, 0, 5, 5, 10, 10, 9, 0));
      send_word(make_word(aabb_pkg::MODE_VERT, 5, 0, 5, 5, 10, 10, 5, 1));
      send_word(make_word(aabb_pkg::MODE_VERT, 5, 0, 5, 5, 10, 10, 5, 0));
      // own entry skipped
      send_word(make_word(aabb_pkg::MODE_HORZ, 0, 0, 5, 5, 10, 10, 0, 0));
      // two overlaps: lower index wins
      send_word(make_word(aabb_pkg::MODE_VERT, 7, 0, 110, 110, 4, 4, 110, 1));
      // touching edges do not overlap
      send_word(make_word(aabb_pkg::MODE_HORZ, 7, 0, 10, 0, 5, 5, 0, 0));
      // zero-size mover inside a box, then on its edge
      send_word(make_word(aabb_pkg::MODE_HORZ, 7, 0, 5, 5, 0, 0, 0, 0));
      send_word(make_word(aabb_pkg::MODE_VERT, 7, 0, 0, 5, 0, 0, 0, 1));
      send_word(make_word(aabb_tb_pkg::MODE_UNUSED, 63, 1, -1, -1, 32767, 32767, -1, 1));
      send_word(make_word(aabb_pkg::MODE_WRITE, 1, 1, -32768, -32768, 32767, 32767, 0, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 0, 0, 0, 0, 0, 0, 0, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 30, 0, 0, 0, 0, 0, 0, 0));
      // resolved positions past the coordinate range
      send_word(make_word(aabb_pkg::MODE_HORZ, 63, 0, -32000, -32000, 32767, 10, -32768, 0));
      send_word(make_word(aabb_pkg::MODE_WRITE, 2, 1, 32767, 32767, 32767, 32767, 0, 0));
      send_word(make_word(aabb_pkg::MODE_HORZ, 63, 0, 32000, 32000, 32767, 32767, 32767, 0));
      send_word(make_word(aabb_pkg::MODE_VERT, 63, 0, 32000, 32000, 32767, 32767, 0, 0));
      send_word(make_word(aabb_pkg::MODE_HORZ, 4, 1, 32767, -32768, 32767, 32767, -1, 1));
      send_word(make_word(aabb_pkg::MODE_WRITE, 0, 1, 0, 0, 10, 10, 0, 0));
      wait_for_results();

      run_random(600, 28);
      wait_for_results();
      run_random(600, 65);
      run_random(600, 0);

      wait_for_results();
      repeat (80) @(posedge clock);
      if (sb.fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_box_table.sv
rtl/aabb_overlap_unit.sv
rtl/aabb_scan_seq.sv
rtl/aabb_collide_and_resolve.sv
rtl/aabb_checker.sv
tb/aabb_tb_pkg.sv
tb/tb_aabb_collide_and_resolve.sv
